/* hdl/prime_composite_classifier_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the prime/composite classifier
// Shared concurrent-check shorthands; clocked on clk, off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PRIME_COMPOSITE_CLASSIFIER_TOP_MACROS_SVH
`define PRIME_COMPOSITE_CLASSIFIER_TOP_MACROS_SVH

// same-cycle implication
`define PCC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcc check failed: same-cycle implication");

// next-cycle implication
`define PCC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcc check failed: next-cycle implication");

`endif

/* hdl/pcc_pkg.sv */
// ----------------------------------------------------------------------------
// pcc_pkg
// Widths, codes and shared types of the prime/composite classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package pcc_pkg;

  localparam int VALUE_BITS = 32;
  // magnitude of a non-negative value
  localparam int MAG_W      = VALUE_BITS - 1;
  // trial divisor: must reach just past sqrt(2**MAG_W)
  localparam int D_W        = (MAG_W + 1) / 2 + 1;
  localparam int SQ_W       = 2 * D_W;
  localparam int CNT_W      = (MAG_W > 1) ? $clog2(MAG_W) : 1;
  localparam int TALLY_W    = 32;
  localparam int CLS_W      = 2;

  typedef enum logic [CLS_W-1:0] {
    CLS_NEITHER   = 2'd0,
    CLS_PRIME     = 2'd1,
    CLS_COMPOSITE = 2'd2
  } cls_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_WAIT_MOD,
    S_FIN
  } state_t;

  typedef struct packed {
    logic done;
    logic zero;
  } mod_res_t;

  typedef struct packed {
    logic en;
    cls_t cls;
  } tally_upd_t;

endpackage

`default_nettype wire

/* hdl/pcc_mod_unit.sv */
// ----------------------------------------------------------------------------
// pcc_mod_unit
// Shared restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pcc_mod_unit import pcc_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [MAG_W-1:0] dividend,
  input  wire logic [D_W-1:0]   divisor,
  output mod_res_t              res
);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [MAG_W-1:0] dvd_r, dvd_nxt;
  logic [D_W-1:0]   rem_r, rem_nxt;
  logic [D_W-1:0]   dsr_r, dsr_nxt;
  logic [D_W:0]     trial;

  assign trial = {rem_r, dvd_r[MAG_W-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(MAG_W - 1);
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      dvd_nxt = dvd_r << 1;
      // remainder stays below the divisor, so it fits in D_W bits
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = D_W'(trial - {1'b0, dsr_r});
      end else begin
        rem_nxt = D_W'(trial);
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign res.done = done_r;
  assign res.zero = (rem_r == '0);

endmodule

`default_nettype wire

/* hdl/pcc_tally.sv */
// ----------------------------------------------------------------------------
// pcc_tally
// Saturating prime and composite counters; shows the totals after an update.
// ----------------------------------------------------------------------------
`default_nettype none

module pcc_tally import pcc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire tally_upd_t         upd,
  output logic [TALLY_W-1:0]      prime_nxt,
  output logic [TALLY_W-1:0]      comp_nxt
);

  logic [TALLY_W-1:0] prime_r;
  logic [TALLY_W-1:0] comp_r;

  always_comb begin
    prime_nxt = prime_r;
    comp_nxt  = comp_r;
    case (upd.cls)
      CLS_PRIME: begin
        if (prime_r != '1) prime_nxt = prime_r + 1'b1;
      end
      CLS_COMPOSITE: begin
        if (comp_r != '1) comp_nxt = comp_r + 1'b1;
      end
      default: begin
        prime_nxt = prime_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prime_r <= '0;
      comp_r  <= '0;
    end else if (upd.en) begin
      prime_r <= prime_nxt;
      comp_r  <= comp_nxt;
    end
  end

endmodule

`default_nettype wire

/* hdl/prime_composite_classifier_top.sv */
// ----------------------------------------------------------------------------
// prime_composite_classifier_top
// Trial-division primality classifier with saturating prime/composite totals.
// ----------------------------------------------------------------------------
// Values at most 1 go straight to the result; otherwise each trial divisor
//   takes one pass through the bit-serial remainder unit.
// Worst case (large prime near 2**31) is about 46340 trial divisors.
// One request in flight; in_stall is high until the result is registered.
// Reset (rst_n low, synchronous) clears the totals, the sequencer and out_valid.
`default_nettype none

`include "prime_composite_classifier_top_macros.svh"

module prime_composite_classifier_top import pcc_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic signed [VALUE_BITS-1:0] in_value,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [CLS_W-1:0]               out_number_class,
  output logic [TALLY_W-1:0]             out_prime_total,
  output logic [TALLY_W-1:0]             out_composite_total
);

  state_t             state_r, state_nxt;
  logic [MAG_W-1:0]   n_r, n_nxt;
  logic [D_W-1:0]     d_r, d_nxt;
  logic [SQ_W-1:0]    sq_r, sq_nxt;
  cls_t               cls_r, cls_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [CLS_W-1:0]   out_cls_r, out_cls_nxt;
  logic [TALLY_W-1:0] out_prime_r, out_prime_nxt;
  logic [TALLY_W-1:0] out_comp_r, out_comp_nxt;

  logic               mod_start;
  mod_res_t           mod_res;
  tally_upd_t         upd;
  logic [TALLY_W-1:0] prime_nxt;
  logic [TALLY_W-1:0] comp_nxt;
  logic               accept;
  logic               in_neg;
  logic [MAG_W-1:0]   in_mag;

  assign accept = in_valid && !in_stall;
  assign in_neg = in_value[VALUE_BITS-1];
  assign in_mag = in_value[MAG_W-1:0];

  pcc_mod_unit u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (n_r),
    .divisor  (d_r),
    .res      (mod_res)
  );

  pcc_tally u_tally (
    .clk       (clk),
    .rst_n     (rst_n),
    .upd       (upd),
    .prime_nxt (prime_nxt),
    .comp_nxt  (comp_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r         <= n_nxt;
    d_r         <= d_nxt;
    sq_r        <= sq_nxt;
    cls_r       <= cls_nxt;
    out_cls_r   <= out_cls_nxt;
    out_prime_r <= out_prime_nxt;
    out_comp_r  <= out_comp_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    d_nxt         = d_r;
    sq_nxt        = sq_r;
    cls_nxt       = cls_r;
    out_cls_nxt   = out_cls_r;
    out_prime_nxt = out_prime_r;
    out_comp_nxt  = out_comp_r;
    out_valid_nxt = out_valid_r && out_stall;
    mod_start     = 1'b0;
    upd.en        = 1'b0;
    upd.cls       = cls_r;
    in_stall      = (state_r != S_IDLE);

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          n_nxt  = in_mag;
          d_nxt  = D_W'(2);
          sq_nxt = SQ_W'(4);
          if (in_neg || in_mag <= MAG_W'(1)) begin
            cls_nxt   = CLS_NEITHER;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        // no divisor up to sqrt(n) left to try
        if (sq_r > SQ_W'(n_r)) begin
          cls_nxt   = CLS_PRIME;
          state_nxt = S_FIN;
        end else begin
          mod_start = 1'b1;
          state_nxt = S_WAIT_MOD;
        end
      end
      S_WAIT_MOD: begin
        if (mod_res.done) begin
          if (mod_res.zero) begin
            cls_nxt   = CLS_COMPOSITE;
            state_nxt = S_FIN;
          end else begin
            // (d+1)^2 = d^2 + 2d + 1
            sq_nxt    = sq_r + SQ_W'({d_r, 1'b1});
            d_nxt     = d_r + 1'b1;
            state_nxt = S_CHECK;
          end
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          upd.en        = (cls_r != CLS_NEITHER);
          out_cls_nxt   = cls_r;
          out_prime_nxt = prime_nxt;
          out_comp_nxt  = comp_nxt;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid           = out_valid_r;
  assign out_number_class    = out_cls_r;
  assign out_prime_total     = out_prime_r;
  assign out_composite_total = out_comp_r;

  `PCC_ASSERT_NXT(a_accept_starts_work, accept, state_r == S_CHECK || state_r == S_FIN)
  `PCC_ASSERT_IMP(a_square_tracks_divisor, state_r == S_CHECK, sq_r == SQ_W'(d_r) * SQ_W'(d_r))
  `PCC_ASSERT_IMP(a_result_from_fin, $rose(out_valid_r), $past(state_r) == S_FIN)

endmodule

`default_nettype wire
